// ----- design/btmx_pkg.sv -----
// ----------------------------------------------------------------------------
// btmx_pkg: shared definitions for the binary trie maximum-XOR engine
// Command and status codes, sequencer states, the result record passed
// from the trie walker to the output stage, and parameter defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package btmx_pkg;

  localparam int KEY_BITS_DEF  = 32;
  localparam int NODE_POOL_DEF = 4096;
  localparam int RES_W         = 32;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FILL,
    S_RESP
  } state_t;

  // Result of one command as handed to the output stage.
  typedef struct packed {
    logic [RES_W-1:0] qx;   // maximum XOR of a query, zero otherwise
    status_t          st;
    logic             upd;  // fold qx into the running maximum
    logic             clr;  // zero the running maximum
  } result_t;

endpackage

`default_nettype wire

// ----- design/btmx_node_ram.sv -----
// ----------------------------------------------------------------------------
// btmx_node_ram: node link memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module btmx_node_ram #(
  parameter int DEPTH = btmx_pkg::NODE_POOL_DEF,
  parameter int WIDTH = 2 * $clog2(btmx_pkg::NODE_POOL_DEF)
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- design/btmx_walker.sv -----
// ----------------------------------------------------------------------------
// btmx_walker: trie sequencer
// Walks the trie one level per cycle through the node memory, allocates
// missing paths on insert and builds the maximum XOR on query.
// ----------------------------------------------------------------------------
`default_nettype none

module btmx_walker #(
  parameter int KEY_BITS  = btmx_pkg::KEY_BITS_DEF,
  parameter int NODE_POOL = btmx_pkg::NODE_POOL_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output      logic              in_ready,
  input  wire logic [1:0]        cmd,
  input  wire logic [31:0]       key_value,
  output      logic              res_valid,
  input  wire logic              res_take,
  output      btmx_pkg::result_t res
);

  localparam int NODE_W = $clog2(NODE_POOL);
  localparam int CNT_W  = $clog2(NODE_POOL + 1);
  localparam int SUM_W  = CNT_W + 1;
  localparam int LVL_W  = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;

  btmx_pkg::state_t state, state_next;
  btmx_pkg::cmd_t   op, op_next;
  btmx_pkg::result_t res_next;

  logic [KEY_BITS-1:0]      key_q, key_next;
  logic [KEY_BITS-1:0]      acc, acc_next, acc_set;
  logic [KEY_BITS+31:0]     acc_wide;
  logic [LVL_W-1:0]         lvl, lvl_next;
  logic                     at_root, at_root_next;
  logic [NODE_W-1:0]        node, node_next;
  logic [CNT_W-1:0]         nodes_used, nodes_used_next;
  logic [1:0][NODE_W-1:0]   root_links, root_links_next;
  logic [1:0][NODE_W-1:0]   cur, rd_data, wr_data;
  logic                     we;
  logic [NODE_W-1:0]        waddr, raddr, fresh;
  logic [SUM_W-1:0]         need;
  logic                     b;

  btmx_node_ram #(
    .DEPTH (NODE_POOL),
    .WIDTH (2 * NODE_W)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wr_data),
    .raddr (raddr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= btmx_pkg::S_IDLE;
      nodes_used <= CNT_W'(1);
      root_links <= '0;
    end else begin
      state      <= state_next;
      nodes_used <= nodes_used_next;
      root_links <= root_links_next;
    end
    op      <= op_next;
    key_q   <= key_next;
    acc     <= acc_next;
    lvl     <= lvl_next;
    at_root <= at_root_next;
    node    <= node_next;
    res     <= res_next;
  end

  always_comb begin
    state_next      = state;
    op_next         = op;
    key_next        = key_q;
    acc_next        = acc;
    lvl_next        = lvl;
    at_root_next    = at_root;
    node_next       = node;
    nodes_used_next = nodes_used;
    root_links_next = root_links;
    res_next        = res;
    we              = 1'b0;
    waddr           = node;
    wr_data         = '0;
    raddr           = node;
    in_ready        = (state == btmx_pkg::S_IDLE);
    res_valid       = (state == btmx_pkg::S_RESP);
    cur             = at_root ? root_links : rd_data;
    b               = key_q[lvl];
    need            = SUM_W'(nodes_used) + SUM_W'(lvl) + SUM_W'(1);
    fresh           = nodes_used[NODE_W-1:0];
    acc_set         = acc | (KEY_BITS'(1) << lvl);
    acc_wide        = '0;

    unique case (state)
      btmx_pkg::S_IDLE: begin
        if (in_valid) begin
          op_next      = btmx_pkg::cmd_t'(cmd);
          key_next     = KEY_BITS'({{KEY_BITS{1'b0}}, key_value});
          acc_next     = '0;
          lvl_next     = LVL_W'(KEY_BITS - 1);
          at_root_next = 1'b1;
          node_next    = '0;
          res_next     = '{qx: '0, st: btmx_pkg::ST_OK, upd: 1'b0, clr: 1'b0};
          unique case (btmx_pkg::cmd_t'(cmd))
            btmx_pkg::CMD_CLEAR: begin
              root_links_next = '0;
              nodes_used_next = CNT_W'(1);
              res_next.clr    = 1'b1;
              state_next      = btmx_pkg::S_RESP;
            end
            btmx_pkg::CMD_INSERT: begin
              state_next = btmx_pkg::S_WALK;
            end
            btmx_pkg::CMD_QUERY: begin
              if (root_links == '0) begin
                res_next.st = btmx_pkg::ST_EMPTY;
                state_next  = btmx_pkg::S_RESP;
              end else begin
                state_next = btmx_pkg::S_WALK;
              end
            end
            default: begin
              state_next = btmx_pkg::S_RESP;
            end
          endcase
        end
      end

      btmx_pkg::S_WALK: begin
        at_root_next = 1'b0;
        if (op == btmx_pkg::CMD_INSERT) begin
          if (cur[b] == '0) begin
            // Path ends here: link the parent to the first new node.
            if (need > SUM_W'(NODE_POOL)) begin
              res_next.st = btmx_pkg::ST_FULL;
              state_next  = btmx_pkg::S_RESP;
            end else begin
              if (at_root) begin
                root_links_next[b] = fresh;
              end else begin
                we         = 1'b1;
                waddr      = node;
                wr_data    = cur;
                wr_data[b] = fresh;
              end
              state_next = btmx_pkg::S_FILL;
            end
          end else if (lvl == '0) begin
            state_next = btmx_pkg::S_RESP;
          end else begin
            node_next = cur[b];
            raddr     = cur[b];
            lvl_next  = lvl - LVL_W'(1);
          end
        end else begin
          if (cur[~b] != '0) begin
            acc_next  = acc_set;
            node_next = cur[~b];
          end else if (cur[b] != '0) begin
            node_next = cur[b];
          end else begin
            state_next = btmx_pkg::S_RESP;
          end
          raddr    = node_next;
          acc_wide = {32'b0, acc_next};
          if (lvl == '0 || state_next == btmx_pkg::S_RESP) begin
            res_next.qx  = acc_wide[31:0];
            res_next.upd = 1'b1;
            state_next   = btmx_pkg::S_RESP;
          end else begin
            lvl_next = lvl - LVL_W'(1);
          end
        end
      end

      btmx_pkg::S_FILL: begin
        // One new node per cycle; each but the last points to the next one down the path.
        we    = 1'b1;
        waddr = fresh;
        if (lvl != '0) begin
          wr_data[key_q[lvl - LVL_W'(1)]] = NODE_W'(nodes_used + CNT_W'(1));
          lvl_next = lvl - LVL_W'(1);
        end else begin
          state_next = btmx_pkg::S_RESP;
        end
        nodes_used_next = nodes_used + CNT_W'(1);
      end

      btmx_pkg::S_RESP: begin
        if (res_take) begin
          state_next = btmx_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = btmx_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- design/binary_trie_max_xor.sv -----
// Throughput: one command at a time, and each walk makes one dependent node
// read per level. The next command beat is taken in the cycle after the
// result moves out.
// Reset: empty trie, one node used (the root), running maximum zero. The node
// memory needs no clearing pass since each node is written when allocated.
// ----------------------------------------------------------------------------
// binary_trie_max_xor: binary trie maximum-XOR engine
// Stores keys in a trie held in a node memory, answers maximum-XOR queries
// and keeps a running maximum of the query results.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_trie_max_xor #(
  parameter int KEY_BITS  = btmx_pkg::KEY_BITS_DEF,
  parameter int NODE_POOL = btmx_pkg::NODE_POOL_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Command stream.
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [31:0] s_tdata,   // [31:0] key_value
  input  wire logic [1:0]  s_tuser,   // [1:0] command
  // Result stream.
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [63:0] m_tdata,   // [31:0] query_xor, [63:32] best_xor
  output      logic [1:0]  m_tuser    // [1:0] status
);

  btmx_pkg::result_t res;
  logic              res_valid;
  logic              res_take;
  logic [31:0]       running_best;
  logic [31:0]       best_next;

  // The walker owns the trie and its node memory. It takes one command at a
  // time and holds its result until the output stage takes it.
  btmx_walker #(
    .KEY_BITS  (KEY_BITS),
    .NODE_POOL (NODE_POOL)
  ) u_walker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .cmd       (s_tuser),
    .key_value (s_tdata),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  // The output register parts the two sides: a result beat can wait here
  // for the consumer while the walker already accepts and works on the next
  // command. The result moves in whenever the register is empty or its beat
  // is being taken in this cycle.
  assign res_take = res_valid && (!m_tvalid || m_tready);

  // The running maximum is folded in as the result moves to the output, so
  // the best_xor field always shows the maximum after this command.
  always_comb begin
    best_next = running_best;
    if (res.clr) begin
      best_next = '0;
    end else if (res.upd && (res.qx > running_best)) begin
      best_next = res.qx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid     <= 1'b0;
      running_best <= '0;
    end else begin
      if (res_take) begin
        m_tvalid     <= 1'b1;
        running_best <= best_next;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
    if (res_take) begin
      m_tdata <= {best_next, res.qx};
      m_tuser <= res.st;
    end
  end

endmodule

`default_nettype wire
